@@ hdl/tidb_pkg.sv @@
// Shared types and constants for the touch id binding table.
package tidb_pkg;

  localparam int unsigned SlotsDefault = 40;
  localparam int unsigned CountW       = 7;
  localparam logic [31:0] TimeoutReset = 32'd2000;

  // request codes
  localparam logic [2:0] REQ_BIND     = 3'd0;
  localparam logic [2:0] REQ_FORCE    = 3'd1;
  localparam logic [2:0] REQ_STATUS   = 3'd2;
  localparam logic [2:0] REQ_ACTIVE   = 3'd3;
  localparam logic [2:0] REQ_RELEASE  = 3'd4;
  localparam logic [2:0] REQ_REL_ALL  = 3'd5;
  localparam logic [2:0] REQ_UNBIND   = 3'd6;
  localparam logic [2:0] REQ_LOOKUP   = 3'd7;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BOUND   = 2'd1;
  localparam logic [1:0] ERR_FULL    = 2'd2;
  localparam logic [1:0] ERR_MISSING = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] raw_finger;
    logic        any_finger;
    logic [15:0] touch_tag;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [15:0]       result_touch_id;
    logic [1:0]        error_code;
    logic [CountW-1:0] active_count;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] finger;
    logic [15:0] touch;
    logic [31:0] btime;
  } slot_t;

endpackage

@@ hdl/touch_id_binding_table.sv @@
// Top level of the touch id binding table: slot ring and request sequencer.
//
// Input channel: in_valid_i / in_stall_o carry one request word (in_word_i).
// Output channel: out_valid_o / out_stall_i carry one response word per
// request. A word moves on a rising edge with valid high and stall low.
// Config: cfg_we_i writes cfg_wdata_i into the timeout register; the user
// must write only while the block is idle; the block does not enforce it.
//
// The SLOTS slots live in a ring of cells that rotates by one every scan
// cycle, so slot k sits in the head cell on scan cycle k. A full turn
// puts every slot back in its place.
// Sequence: one turn of the ring to scan, a decision state, a second
// turn when a successful bind or force writes a slot, and a final state
// that loads the output register. One request is in flight at a time:
// the block takes no new request until it is done with the last one.
// in_stall_o is high while a request is in flight. A finished response
// waits in the output register while the receiver stalls; the next
// request may be accepted meanwhile, and its response holds until the
// register is free.
// Reset: every slot free, id counter and active count zero, timeout 2000.
module touch_id_binding_table #(
  parameter int unsigned SLOTS = tidb_pkg::SlotsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tidb_pkg::req_t in_word_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tidb_pkg::rsp_t out_word_o,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LastIdx = CW'(SLOTS - 1);
  localparam int unsigned KW = tidb_pkg::CountW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  tidb_pkg::req_t   req_q;
  logic [31:0]      timeout_q;
  logic [15:0]      next_id_q, next_id_d;
  logic [KW-1:0]    count_q, count_d;
  logic             hit_q, hit_d, hit_old_q, hit_old_d, open_q, open_d;
  logic             stat_q, stat_d;
  logic [CW-1:0]    hit_idx_q, hit_idx_d, open_idx_q, open_idx_d, tgt_q, tgt_d;
  logic [15:0]      hit_touch_q, hit_touch_d;
  tidb_pkg::rsp_t   rsp_q, rsp_d;
  tidb_pkg::rsp_t   out_q;
  logic             out_valid_q;

  tidb_pkg::slot_t  ring [SLOTS];
  tidb_pkg::slot_t  head, head_mod;
  logic             shift, clr_all;
  logic [SLOTS-1:0] valid_vec;
  logic             match_f, match_t, in_acc, out_free;

  // ring of slot cells; the head's modified copy re-enters at the tail
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    tidb_pkg::slot_t nxt;
    if (g == SLOTS - 1) begin : g_tail
      assign nxt = head_mod;
    end else begin : g_mid
      assign nxt = ring[g+1];
    end
    tidb_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .clr_all_i(clr_all),
      .slot_i   (nxt),
      .slot_o   (ring[g])
    );
    assign valid_vec[g] = ring[g].valid;
  end

  assign head    = ring[0];
  assign match_f = head.valid && (head.finger == req_q.raw_finger);
  assign match_t = head.valid && (head.touch == req_q.touch_tag);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    next_id_d   = next_id_q;
    count_d     = count_q;
    hit_d       = hit_q;
    hit_old_d   = hit_old_q;
    hit_idx_d   = hit_idx_q;
    hit_touch_d = hit_touch_q;
    open_d      = open_q;
    open_idx_d  = open_idx_q;
    stat_d      = stat_q;
    tgt_d       = tgt_q;
    rsp_d       = rsp_q;
    head_mod    = head;
    shift       = 1'b0;
    clr_all     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          hit_d   = 1'b0;
          open_d  = 1'b0;
          stat_d  = 1'b0;
        end
      end
      S_SCAN: begin
        shift = 1'b1;
        // first match ends the search; free slots count only before it
        if (!hit_q) begin
          if (match_f) begin
            hit_d       = 1'b1;
            hit_idx_d   = cnt_q;
            hit_touch_d = head.touch;
            hit_old_d   = (req_q.now_ms - head.btime) > timeout_q;
          end else if (!head.valid) begin
            open_d     = 1'b1;
            open_idx_d = cnt_q;
          end
        end
        case (req_q.req_type)
          tidb_pkg::REQ_STATUS: begin
            if (match_t && (req_q.any_finger || match_f)) stat_d = 1'b1;
          end
          tidb_pkg::REQ_RELEASE: begin
            if (match_f) begin
              head_mod.valid = 1'b0;
              count_d = count_q - KW'(1);
              stat_d  = 1'b1;
            end
          end
          tidb_pkg::REQ_UNBIND: begin
            if (match_t) begin
              head_mod.valid = 1'b0;
              count_d = count_q - KW'(1);
              stat_d  = 1'b1;
            end
          end
          default: ;
        endcase
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == LastIdx) state_d = S_DEC;
      end
      S_DEC: begin
        rsp_d = '{ok: 1'b0, result_touch_id: 16'd0,
                  error_code: tidb_pkg::ERR_NONE, active_count: count_q};
        state_d = S_FIN;
        cnt_d   = '0;
        case (req_q.req_type)
          tidb_pkg::REQ_BIND, tidb_pkg::REQ_FORCE: begin
            if (hit_q && (hit_old_q || req_q.req_type == tidb_pkg::REQ_FORCE)) begin
              tgt_d   = hit_idx_q;
              state_d = S_WRITE;
            end else if (hit_q) begin
              rsp_d.error_code = tidb_pkg::ERR_BOUND;
            end else if (open_q) begin
              tgt_d   = open_idx_q;
              count_d = count_q + KW'(1);
              state_d = S_WRITE;
            end else begin
              rsp_d.error_code = tidb_pkg::ERR_FULL;
            end
            if (state_d == S_WRITE) begin
              rsp_d.ok = 1'b1;
              rsp_d.result_touch_id = next_id_q;
              rsp_d.active_count = count_d;
              next_id_d = next_id_q + 16'd1;
            end
          end
          tidb_pkg::REQ_ACTIVE: begin
            rsp_d.ok = hit_q;
            if (!hit_q) rsp_d.error_code = tidb_pkg::ERR_MISSING;
          end
          tidb_pkg::REQ_LOOKUP: begin
            rsp_d.ok = hit_q;
            if (hit_q) rsp_d.result_touch_id = hit_touch_q;
            else rsp_d.error_code = tidb_pkg::ERR_MISSING;
          end
          tidb_pkg::REQ_REL_ALL: begin
            clr_all = 1'b1;
            count_d = '0;
            rsp_d.ok = 1'b1;
            rsp_d.active_count = '0;
          end
          default: begin
            // status, release, unbind
            rsp_d.ok = stat_q;
            if (!stat_q) rsp_d.error_code = tidb_pkg::ERR_MISSING;
          end
        endcase
      end
      S_WRITE: begin
        shift = 1'b1;
        if (cnt_q == tgt_q) begin
          head_mod = '{valid: 1'b1, finger: req_q.raw_finger,
                       touch: rsp_q.result_touch_id, btime: req_q.now_ms};
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == LastIdx) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      next_id_q   <= '0;
      count_q     <= '0;
      timeout_q   <= tidb_pkg::TimeoutReset;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      open_q      <= 1'b0;
      stat_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      next_id_q <= next_id_d;
      count_q   <= count_d;
      hit_q     <= hit_d;
      open_q    <= open_d;
      stat_q    <= stat_d;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_word_i;
    hit_old_q   <= hit_old_d;
    hit_idx_q   <= hit_idx_d;
    hit_touch_q <= hit_touch_d;
    open_idx_q  <= open_idx_d;
    tgt_q       <= tgt_d;
    rsp_q       <= rsp_d;
    if (state_q == S_FIN && out_free) out_q <= rsp_q;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // active count never exceeds the table size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= KW'(SLOTS))
    else $error("active count above slot count");

  // between requests the count agrees with the ring's valid bits
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> count_q == KW'($countones(valid_vec)))
    else $error("active count out of step with slot valid bits");

  // success and an error code never go together
  a_ok_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.ok == (out_word_o.error_code == tidb_pkg::ERR_NONE)))
    else $error("ok and error code disagree");

  // an accepted request starts a scan
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_SCAN)
    else $error("request accepted without scan");

endmodule

@@ hdl/tidb_cell.sv @@
// One slot cell of the rotating slot ring.
module tidb_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           clr_all_i,
  input  tidb_pkg::slot_t slot_i,
  output tidb_pkg::slot_t slot_o
);

  logic                valid_q;
  logic [31:0]         finger_q;
  logic [15:0]         touch_q;
  logic [31:0]         btime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_all_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      finger_q <= slot_i.finger;
      touch_q  <= slot_i.touch;
      btime_q  <= slot_i.btime;
    end
  end

  assign slot_o = '{valid: valid_q, finger: finger_q, touch: touch_q, btime: btime_q};

endmodule

@@ verif/touch_id_binding_table_tb.sv @@
// Self-checking testbench for the touch id binding table.
`timescale 1ns / 1ps

module touch_id_binding_table_tb;

  localparam int unsigned NumSlots  = 40;
  localparam int unsigned RandItems = 1800;
  localparam int unsigned DogLimit  = 20000;
  localparam int unsigned IdleCyc   = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tidb_pkg::req_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  tidb_pkg::rsp_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  always #4 clk_i = ~clk_i;

  touch_id_binding_table #(.SLOTS(NumSlots)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o, .cfg_we_i, .cfg_wdata_i
  );

  // Shadow copy of the table, updated as each word is accepted.
  logic              tbl_valid [NumSlots];
  logic [31:0]       tbl_finger[NumSlots];
  logic [15:0]       tbl_touch [NumSlots];
  logic [31:0]       tbl_btime [NumSlots];
  logic [15:0]       id_ctr;
  logic [tidb_pkg::CountW-1:0] live_cnt;
  logic [31:0]       timeout_reg;

  tidb_pkg::req_t req_q[$];   // words waiting to be driven
  tidb_pkg::rsp_t rsp_q[$];   // expected responses, oldest first
  int   n_fail = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   n_ok = 0;
  bit   hold_rx = 1'b0;   // receiver long hold-off request
  bit   stim_done = 1'b0;

  function automatic logic [15:0] claim_slot(int s, logic [31:0] f, logic [31:0] t);
    logic [15:0] id;
    id = id_ctr;
    tbl_valid[s] = 1'b1;
    tbl_finger[s] = f;
    tbl_touch[s] = id;
    tbl_btime[s] = t;
    id_ctr = id_ctr + 16'd1;
    return id;
  endfunction

  // Predicts one response and advances the shadow table.
  function automatic tidb_pkg::rsp_t table_response(tidb_pkg::req_t r);
    tidb_pkg::rsp_t o;
    int hit, open;
    hit = -1;
    open = -1;
    o = '0;
    o.error_code = tidb_pkg::ERR_NONE;
    // first matching slot ends the scan; free slots seen so far tracked
    for (int i = 0; i < NumSlots; i++) begin
      if (tbl_valid[i] && tbl_finger[i] == r.raw_finger) begin
        hit = i;
        break;
      end
      if (!tbl_valid[i]) open = i;
    end
    case (r.req_type)
      tidb_pkg::REQ_BIND, tidb_pkg::REQ_FORCE: begin
        if (hit >= 0) begin
          if (r.req_type == tidb_pkg::REQ_FORCE ||
              (r.now_ms - tbl_btime[hit]) > timeout_reg) begin
            o.result_touch_id = claim_slot(hit, r.raw_finger, r.now_ms);
            o.ok = 1'b1;
          end else begin
            o.error_code = tidb_pkg::ERR_BOUND;
          end
        end else if (open >= 0) begin
          o.result_touch_id = claim_slot(open, r.raw_finger, r.now_ms);
          o.ok = 1'b1;
          live_cnt++;
        end else begin
          o.error_code = tidb_pkg::ERR_FULL;
        end
      end
      tidb_pkg::REQ_STATUS: begin
        for (int i = 0; i < NumSlots; i++)
          if (tbl_valid[i] && tbl_touch[i] == r.touch_tag &&
              (r.any_finger || tbl_finger[i] == r.raw_finger)) begin
            o.ok = 1'b1;
            break;
          end
        if (!o.ok) o.error_code = tidb_pkg::ERR_MISSING;
      end
      tidb_pkg::REQ_ACTIVE: begin
        if (hit >= 0) o.ok = 1'b1;
        else o.error_code = tidb_pkg::ERR_MISSING;
      end
      tidb_pkg::REQ_RELEASE, tidb_pkg::REQ_UNBIND: begin
        for (int i = 0; i < NumSlots; i++)
          if (tbl_valid[i] && ((r.req_type == tidb_pkg::REQ_RELEASE) ?
              tbl_finger[i] == r.raw_finger : tbl_touch[i] == r.touch_tag)) begin
            tbl_valid[i] = 1'b0;
            live_cnt--;
            o.ok = 1'b1;
          end
        if (!o.ok) o.error_code = tidb_pkg::ERR_MISSING;
      end
      tidb_pkg::REQ_REL_ALL: begin
        for (int i = 0; i < NumSlots; i++) tbl_valid[i] = 1'b0;
        live_cnt = '0;
        o.ok = 1'b1;
      end
      default: begin
        if (hit >= 0) begin
          o.result_touch_id = tbl_touch[hit];
          o.ok = 1'b1;
        end else begin
          o.error_code = tidb_pkg::ERR_MISSING;
        end
      end
    endcase
    o.active_count = live_cnt;
    return o;
  endfunction

  // Driver: pops the pending queue, random gap before each word.
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rsp_q.push_back(table_response(in_word_i));
        n_in++;
        tx_gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) tx_gap = 0;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_word_i <= req_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted response, draws receiver stalls.
  int rx_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (rsp_q.size() == 0) begin
          $error("response with none expected: %h", out_word_o);
          n_fail++;
        end else begin
          tidb_pkg::rsp_t e;
          e = rsp_q.pop_front();
          if (e.ok) n_ok++;
          if (out_word_o.ok !== e.ok) begin
            $error("ok exp %0d got %0d", e.ok, out_word_o.ok);
            n_fail++;
          end
          if (out_word_o.result_touch_id !== e.result_touch_id) begin
            $error("result_touch_id exp %0d got %0d", e.result_touch_id,
                   out_word_o.result_touch_id);
            n_fail++;
          end
          if (out_word_o.error_code !== e.error_code) begin
            $error("error_code exp %0d got %0d", e.error_code, out_word_o.error_code);
            n_fail++;
          end
          if (out_word_o.active_count !== e.active_count) begin
            $error("active_count exp %0d got %0d", e.active_count,
                   out_word_o.active_count);
            n_fail++;
          end
        end
        rx_gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) rx_gap = 0;
      end
      if (hold_rx && hold_cnt == 0) hold_cnt = 600;
      if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) hold_rx = 1'b0;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: cycles without any accepted word.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet = 0;
    else if (++quiet >= DogLimit) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Finger pool kept small so random requests hit bound fingers often.
  logic [31:0] finger_pool[8] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                                  32'h5A5A_A5A5, 32'h1234_5678, 32'hA5A5_5A5A, 32'h7FFF_FFFF};
  logic [31:0] clock_ms = 32'd0;
  logic [15:0] id_tail = 16'd0;  // rough running copy of the id counter

  function automatic tidb_pkg::req_t mk_req(logic [2:0] op, logic [31:0] f, logic [15:0] t,
                                            logic any, logic [31:0] ms);
    tidb_pkg::req_t r;
    r.req_type = op;
    r.raw_finger = f;
    r.touch_tag = t;
    r.any_finger = any;
    r.now_ms = ms;
    return r;
  endfunction

  function automatic tidb_pkg::req_t rand_req();
    tidb_pkg::req_t r;
    int k;
    k = $urandom_range(0, 99);
    // binds dominate so the table fills; the rest spread across requests
    if (k < 40) begin
      r.req_type = ($urandom_range(0, 3) == 0) ? tidb_pkg::REQ_FORCE : tidb_pkg::REQ_BIND;
    end else if (k < 41) begin
      r.req_type = tidb_pkg::REQ_REL_ALL;
    end else begin
      r.req_type = 3'($urandom_range(0, 7));
      if (r.req_type == tidb_pkg::REQ_REL_ALL) r.req_type = tidb_pkg::REQ_LOOKUP;
    end
    r.raw_finger = ($urandom_range(0, 3) == 0) ? $urandom() :
                   (($urandom_range(0, 1)) ? finger_pool[$urandom_range(0, 7)] :
                    32'($urandom_range(0, 63)));
    r.any_finger = 1'($urandom_range(0, 1));
    // touch ids near the counter so status and unbind hit
    r.touch_tag = ($urandom_range(0, 4) == 0) ? 16'($urandom()) :
                  id_tail - 16'($urandom_range(0, 80));
    clock_ms = clock_ms + (($urandom_range(0, 9) == 0) ? $urandom() :
                           32'($urandom_range(0, 800)));
    r.now_ms = clock_ms;
    return r;
  endfunction

  task automatic wait_drained();
    while (req_q.size() > 0 || in_valid_i || rsp_q.size() > 0) @(posedge clk_i);
    repeat (IdleCyc) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    timeout_reg = v;
  endtask

  logic [31:0] tmo_set[5] = '{32'd0, 32'hFFFF_FFFF, 32'd2000, 32'd1, 32'd500};

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_finger[i] = '0;
      tbl_touch[i] = '0;
      tbl_btime[i] = '0;
    end
    id_ctr = '0;
    live_cnt = '0;
    timeout_reg = tidb_pkg::TimeoutReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: lookup, status, release, unbind and bind on an empty table, then
    // bind age cases at reset timeout, wrapped tick, status by id and by id plus finger.
    req_q.push_back(mk_req(tidb_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_STATUS, 32'h0, 16'h0, 1'b1, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_RELEASE, 32'h0, 16'h0, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_UNBIND, 32'h0, 16'h0, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_BIND, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'hFFFF_FF00));
    req_q.push_back(mk_req(tidb_pkg::REQ_BIND, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'd1000));
    req_q.push_back(mk_req(tidb_pkg::REQ_BIND, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'd1872));
    req_q.push_back(mk_req(tidb_pkg::REQ_BIND, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'd3873));
    req_q.push_back(mk_req(tidb_pkg::REQ_FORCE, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'd3873));
    req_q.push_back(mk_req(tidb_pkg::REQ_FORCE, 32'h0, 16'h0, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_ACTIVE, 32'h0, 16'h0, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_STATUS, 32'h0, 16'd4, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_STATUS, 32'h1, 16'd4, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_STATUS, 32'h1, 16'd4, 1'b1, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_UNBIND, 32'h0, 16'd3, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_RELEASE, 32'h0, 16'h0, 1'b0, 32'd0));
    // fill the table past full, then clear it
    for (int i = 0; i < NumSlots + 2; i++)
      req_q.push_back(mk_req(tidb_pkg::REQ_BIND, 32'(i + 100), 16'h0, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_FORCE, 32'd7, 16'h0, 1'b0, 32'd0));
    req_q.push_back(mk_req(tidb_pkg::REQ_REL_ALL, 32'd0, 16'h0, 1'b0, 32'd0));
    id_tail = 16'd50;
    wait_drained();

    // Random phases, one per timeout setting; phase two begins with a long
    // receiver hold-off while the sender keeps offering words.
    foreach (tmo_set[p]) begin
      write_timeout(tmo_set[p]);
      if (p == 1) hold_rx = 1'b1;
      for (int i = 0; i < RandItems / 5; i++) begin
        tidb_pkg::req_t r;
        r = rand_req();
        req_q.push_back(r);
        if (r.req_type <= tidb_pkg::REQ_FORCE) id_tail = id_tail + 16'd1;
      end
      wait_drained();
    end

    $display("%0d requests driven, %0d responses checked (%0d ok) over %0d timeout settings",
             n_in, n_out, n_ok, 5);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ touch_id_binding_table.f @@
hdl/tidb_pkg.sv
hdl/tidb_cell.sv
hdl/touch_id_binding_table.sv
verif/touch_id_binding_table_tb.sv
